>>> rtl/jdmp_pkg.sv
// shared types, character codes and the control store of the packet mixer
package jdmp_pkg;

    localparam logic [9:0] DEADBAND_RESET = 10'd10;

    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_NL    = 8'h0A;

    typedef logic [3:0] upc_t;

    localparam upc_t UC_LAST = 4'd13;

    // datapath operation of one step
    typedef enum logic [2:0] {
        DP_NONE,
        DP_MAP,
        DP_FIX,
        DP_MIX,
        DP_DIG
    } dp_op_t;

    // byte produced by one step
    typedef enum logic [2:0] {
        EM_NONE,
        EM_CHAR,
        EM_SIGN,
        EM_HUND,
        EM_TENS,
        EM_UNIT,
        EM_FLAG
    } emit_t;

    // sequencing of one step
    typedef enum logic [1:0] {
        JP_NEXT,
        JP_LOOP,
        JP_END
    } jump_t;

    typedef struct packed {
        dp_op_t     dp;
        emit_t      emit;
        logic       flag_sel;
        logic [7:0] chr;
        logic       last;
        jump_t      jump;
        upc_t       target;
    } uword_t;

    // control store
    function automatic uword_t ucode_rom(input upc_t pc);
        uword_t w;
        w = '{DP_NONE, EM_NONE, 1'b0, 8'h00, 1'b0, JP_NEXT, 4'd0};
        case (pc)
            4'd0: begin
                w.dp = DP_MAP;
            end
            4'd1: begin
                w.dp     = DP_FIX;
                w.jump   = JP_LOOP;
                w.target = 4'd0;
            end
            4'd2: begin
                w.dp   = DP_MIX;
                w.emit = EM_CHAR;
                w.chr  = CH_LT;
            end
            4'd3: begin
                w.dp = DP_DIG;
            end
            4'd4: begin
                w.emit = EM_SIGN;
            end
            4'd5: begin
                w.emit = EM_HUND;
            end
            4'd6: begin
                w.emit = EM_TENS;
            end
            4'd7: begin
                w.emit = EM_UNIT;
            end
            4'd8: begin
                w.emit   = EM_CHAR;
                w.chr    = CH_COMMA;
                w.jump   = JP_LOOP;
                w.target = 4'd3;
            end
            4'd9: begin
                w.emit     = EM_FLAG;
                w.flag_sel = 1'b0;
            end
            4'd10: begin
                w.emit = EM_CHAR;
                w.chr  = CH_COMMA;
            end
            4'd11: begin
                w.emit     = EM_FLAG;
                w.flag_sel = 1'b1;
            end
            4'd12: begin
                w.emit = EM_CHAR;
                w.chr  = CH_GT;
            end
            4'd13: begin
                w.emit = EM_CHAR;
                w.chr  = CH_NL;
                w.last = 1'b1;
                w.jump = JP_END;
            end
            default: begin
                w.jump = JP_END;
            end
        endcase
        return w;
    endfunction

endpackage

>>> rtl/joystick_drive_mixer_packet.sv
// joystick drive mixer with dead zone, framing each sample set as a text packet
// the first byte ("<") is written by the mix step, after the map and fix steps of all four axes
// sequencing: an item runs 38 steps (two per axis, one mix, six per number, five for the tail;
//   dropped digit steps still run) plus output stalls; a new item is taken only when idle
// reset: synchronous active-low aresetn clears the sequencer, the output valid
//   and sets the deadband to 10; sample, axis and digit registers are not reset
module joystick_drive_mixer_packet
    import jdmp_pkg::*;
#(
    parameter int SAMPLE_BITS = 10
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    // dead zone register write
    input  logic                                   cfg_wr_en,
    input  logic [9:0]                             cfg_wr_data,
    // sample set in
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    // lsb up: left_stick_x, left_stick_y, right_stick_x, right_stick_y,
    //   switch_one_level, switch_two_level, zero fill
    input  logic [((4*SAMPLE_BITS+2+7)/8)*8-1:0]   s_tdata,
    // packet bytes out
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    // lsb up: packet_byte
    output logic [7:0]                             m_tdata,
    // last_byte
    output logic                                   m_tlast
);

    localparam int N  = SAMPLE_BITS;
    localparam int XW = SAMPLE_BITS + 9;           // raw * 510
    localparam int CW = (SAMPLE_BITS > 10) ? SAMPLE_BITS : 10;
    localparam logic [N-1:0]  CENTRE = {1'b1, {(N-1){1'b0}}};
    localparam logic [XW-1:0] FULL_X = XW'((1 << SAMPLE_BITS) - 1);
    localparam logic [XW-1:0] GAIN_X = XW'(510);

    // control registers
    logic       busy_reg,  busy_next;
    upc_t       pc_reg,    pc_next;
    logic [1:0] cnt_reg,   cnt_next;
    logic [9:0] dz_reg,    dz_next;
    logic       mval_reg,  mval_next;

    // payload registers
    logic        [N-1:0]  raw_reg [4];
    logic        [1:0]    flag_reg;
    logic        [XW-1:0] x_reg;
    logic        [8:0]    q0_reg;
    logic                 dead_reg;
    logic signed [8:0]    map_reg [4];
    logic signed [8:0]    val_reg [4];
    logic                 neg_reg;
    logic        [1:0]    hund_reg;
    logic        [3:0]    tens_reg;
    logic        [3:0]    unit_reg;
    logic        [7:0]    mdata_reg;
    logic                 mlast_reg;

    uword_t uw;
    logic   s_accept;
    logic   out_free;
    logic   emit_want;
    logic   fire;
    logic [7:0] emit_byte;

    // axis map step: scale and dead-zone test
    logic [N-1:0]  map_raw;
    logic [N-1:0]  map_off;
    logic          map_dead;
    logic [XW-1:0] map_x;
    logic [XW:0]   map_sum;
    logic [8:0]    map_q0;

    // axis fix step: one correction of the reciprocal estimate
    logic [XW-1:0]     fix_prod;
    logic [XW-1:0]     fix_rem;
    logic [8:0]        fix_q;
    logic signed [8:0] fix_val;

    // mix step
    logic signed [10:0] ax_w, ay_w;
    logic signed [10:0] left_sum, right_sum;

    // digit step
    logic signed [8:0] dig_v;
    logic [8:0]        dig_neg_v;
    logic [7:0]        dig_mag;
    logic [1:0]        dig_hund;
    logic [7:0]        dig_rem8;
    logic [6:0]        dig_rem;
    logic [13:0]       dig_prod;
    logic [3:0]        dig_tens;
    logic [6:0]        dig_unit7;

    function automatic logic signed [8:0] clamp_axis(input logic signed [10:0] s);
        logic signed [8:0] r;
        if (s > 11'sd255) begin
            r = 9'sd255;
        end else if (s < -11'sd255) begin
            r = -9'sd255;
        end else begin
            r = s[8:0];
        end
        return r;
    endfunction

    assign s_accept = s_tvalid && s_tready;
    assign s_tready = !busy_reg;
    assign out_free = !mval_reg || m_tready;
    assign uw       = ucode_rom(pc_reg);

    // byte gating: sign, leading hundreds and tens are dropped when not needed
    always_comb begin
        case (uw.emit)
            EM_NONE: emit_want = 1'b0;
            EM_CHAR: emit_want = 1'b1;
            EM_SIGN: emit_want = neg_reg;
            EM_HUND: emit_want = (hund_reg != 2'd0);
            EM_TENS: emit_want = (hund_reg != 2'd0) || (tens_reg != 4'd0);
            EM_UNIT: emit_want = 1'b1;
            EM_FLAG: emit_want = 1'b1;
            default: emit_want = 1'b0;
        endcase
    end

    always_comb begin
        case (uw.emit)
            EM_CHAR: emit_byte = uw.chr;
            EM_SIGN: emit_byte = CH_MINUS;
            EM_HUND: emit_byte = CH_ZERO + {6'd0, hund_reg};
            EM_TENS: emit_byte = CH_ZERO + {4'd0, tens_reg};
            EM_UNIT: emit_byte = CH_ZERO + {4'd0, unit_reg};
            EM_FLAG: emit_byte = CH_ZERO + {7'd0, flag_reg[uw.flag_sel]};
            default: emit_byte = uw.chr;
        endcase
    end

    // a step holds while its byte cannot enter the output register
    assign fire = busy_reg && (!emit_want || out_free);

    // sequencer
    always_comb begin
        busy_next = busy_reg;
        pc_next   = pc_reg;
        cnt_next  = cnt_reg;
        dz_next   = dz_reg;
        mval_next = mval_reg;
        if (cfg_wr_en) begin
            dz_next = cfg_wr_data;
        end
        if (m_tready) begin
            mval_next = 1'b0;
        end
        if (fire && emit_want) begin
            mval_next = 1'b1;
        end
        if (s_accept) begin
            busy_next = 1'b1;
            pc_next   = '0;
            cnt_next  = '0;
        end else if (fire) begin
            case (uw.jump)
                JP_NEXT: begin
                    pc_next = pc_reg + 4'd1;
                end
                JP_LOOP: begin
                    cnt_next = cnt_reg + 2'd1;
                    pc_next  = (cnt_reg == 2'd3) ? pc_reg + 4'd1 : uw.target;
                end
                JP_END: begin
                    busy_next = 1'b0;
                    pc_next   = '0;
                end
                default: begin
                    busy_next = 1'b0;
                    pc_next   = '0;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            pc_reg   <= '0;
            cnt_reg  <= '0;
            dz_reg   <= DEADBAND_RESET;
            mval_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            pc_reg   <= pc_next;
            cnt_reg  <= cnt_next;
            dz_reg   <= dz_next;
            mval_reg <= mval_next;
        end
    end

    // map: offset from centre, raw * 510 and quotient estimate by 2^N - 1
    always_comb begin
        map_raw  = raw_reg[cnt_reg];
        map_off  = (map_raw >= CENTRE) ? map_raw - CENTRE : CENTRE - map_raw;
        map_dead = CW'(map_off) < CW'(dz_reg);
        map_x    = XW'(map_raw) * GAIN_X;
        map_sum  = {1'b0, map_x} + {1'b0, (map_x >> N)};
        map_q0   = map_sum[N+8:N];
    end

    // fix: estimate is low by at most one
    always_comb begin
        fix_prod = (XW'(q0_reg) << N) - XW'(q0_reg);
        fix_rem  = x_reg - fix_prod;
        fix_q    = q0_reg + {8'd0, (fix_rem >= FULL_X)};
        fix_val  = dead_reg ? 9'sd0 : 9'({1'b0, fix_q} - 10'd255);
    end

    // mix: rotated left stick into wheel speeds
    always_comb begin
        ax_w      = {{2{map_reg[0][8]}}, map_reg[0]};
        ay_w      = {{2{map_reg[1][8]}}, map_reg[1]};
        left_sum  = ay_w - ax_w;
        right_sum = 11'sd0 - ax_w - ay_w;
    end

    // digits of a magnitude up to 255; tens via multiply by 103 / 1024
    always_comb begin
        dig_v     = val_reg[cnt_reg];
        dig_neg_v = 9'd0 - dig_v;
        dig_mag   = dig_v[8] ? dig_neg_v[7:0] : dig_v[7:0];
        if (dig_mag >= 8'd200) begin
            dig_hund = 2'd2;
            dig_rem8 = dig_mag - 8'd200;
        end else if (dig_mag >= 8'd100) begin
            dig_hund = 2'd1;
            dig_rem8 = dig_mag - 8'd100;
        end else begin
            dig_hund = 2'd0;
            dig_rem8 = dig_mag;
        end
        dig_rem   = dig_rem8[6:0];
        dig_prod  = {7'd0, dig_rem} * 14'd103;
        dig_tens  = dig_prod[13:10];
        dig_unit7 = dig_rem - ({3'd0, dig_tens} * 7'd10);
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            for (int i = 0; i < 4; i++) begin
                raw_reg[i] <= s_tdata[i*N +: N];
            end
            flag_reg <= ~s_tdata[4*N+1:4*N];
        end
        if (fire) begin
            case (uw.dp)
                DP_MAP: begin
                    x_reg    <= map_x;
                    q0_reg   <= map_q0;
                    dead_reg <= map_dead;
                end
                DP_FIX: begin
                    map_reg[cnt_reg] <= fix_val;
                end
                DP_MIX: begin
                    val_reg[0] <= clamp_axis(left_sum);
                    val_reg[1] <= clamp_axis(right_sum);
                    val_reg[2] <= map_reg[3];
                    val_reg[3] <= 9'sd0 - map_reg[2];
                end
                DP_DIG: begin
                    neg_reg  <= dig_v[8];
                    hund_reg <= dig_hund;
                    tens_reg <= dig_tens;
                    unit_reg <= dig_unit7[3:0];
                end
                default: begin
                end
            endcase
        end
        if (fire && emit_want) begin
            mdata_reg <= emit_byte;
            mlast_reg <= uw.last;
        end
    end

    assign m_tvalid = mval_reg;
    assign m_tdata  = mdata_reg;
    assign m_tlast  = mlast_reg;

    a_accept_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> busy_reg && (pc_reg == 4'd0) && (cnt_reg == 2'd0))
        else $error("sequencer did not start at step zero");

    a_last_is_newline: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tlast) |-> (m_tdata == CH_NL))
        else $error("last byte is not a newline");

    a_byte_alphabet: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ((m_tdata >= CH_ZERO) && (m_tdata <= CH_NINE)) ||
            (m_tdata == CH_MINUS) || (m_tdata == CH_LT) || (m_tdata == CH_GT) ||
            (m_tdata == CH_COMMA) || (m_tdata == CH_NL))
        else $error("byte outside packet alphabet");

    a_idle_counter: assert property (@(posedge aclk) disable iff (!aresetn)
        !busy_reg |-> (cnt_reg == 2'd0))
        else $error("loop counter not cleared when idle");

    a_pc_range: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> (pc_reg <= UC_LAST))
        else $error("step counter beyond program");

endmodule
